// ===== rtl/core/ggc_pkg.sv =====
// ggc_pkg: shared constants, controller state type and command/status structs
// for the greedy graph coloring unit; used by every module in rtl/core
`default_nettype none

package ggc_pkg;

    // default graph size limit
    localparam int MAX_VERTICES_DEF = 32;

    // fixed port widths
    localparam int VCOUNT_W = 6;
    localparam int VERTEX_W = 6;
    localparam int INDEX_W  = 5;
    localparam int COLOR_W  = 5;
    localparam int USED_W   = 6;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEARCH,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } ggc_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_edge;
        logic start;
        logic scan_step;
        logic search_step;
        logic commit;
        logic emit_read;
        logic emit_load;
    } ggc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_req;
        logic scan_end;
        logic search_done;
        logic last_vertex;
        logic out_free;
    } ggc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/ggc_ctrl.sv =====
// ggc_ctrl: sequencing state machine for edge loading, coloring and emission
// depends on ggc_pkg for the state enum and the command/status structs
`default_nettype none

module ggc_ctrl
    import ggc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ggc_sts_t sts,
    input  wire logic     in_valid,
    output logic          in_stall,
    output ggc_cmd_t      cmd
);

    ggc_state_t state_reg;
    ggc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.start_req)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (sts.search_done)
                begin
                    state_next = sts.last_vertex ? ST_EMIT_RD : ST_SCAN;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.last_vertex ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_edge = in_valid;
                cmd.start     = in_valid && sts.start_req;
            end
            ST_SCAN:
            begin
                cmd.scan_step = !sts.scan_end;
            end
            ST_SEARCH:
            begin
                cmd.search_step = !sts.search_done;
                cmd.commit      = sts.search_done;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_read = 1'b1;
            end
            ST_EMIT_WAIT:
            begin
                cmd.emit_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/ggc_datapath.sv =====
// ggc_datapath: adjacency matrix, color memory, scan counters, output register
// and the vertex count register; depends on ggc_pkg for widths and structs
`default_nettype none

module ggc_datapath
    import ggc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ggc_cmd_t            cmd,
    output ggc_sts_t                 sts,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [VCOUNT_W-1:0] cfg_data,
    input  wire logic [VERTEX_W-1:0] vertex_a,
    input  wire logic [VERTEX_W-1:0] vertex_b,
    input  wire logic                last_edge,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [INDEX_W-1:0]       vertex_index,
    output logic [COLOR_W-1:0]       color,
    output logic [USED_W-1:0]        colors_used,
    output logic                     bad_edge_seen,
    output logic                     last_result
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int EW = (CW > VCOUNT_W) ? CW : VCOUNT_W;

    logic [VCOUNT_W-1:0]     vcount_reg;
    logic [MAX_VERTICES-1:0] adj_reg [MAX_VERTICES];
    logic [VW-1:0]           color_mem [MAX_VERTICES];
    logic                    bad_flag_reg;
    logic [VW-1:0]           u_reg;
    logic [VW-1:0]           v_reg;
    logic [VW-1:0]           c_reg;
    logic [VW-1:0]           maxc_reg;
    logic [MAX_VERTICES-1:0] taken_reg;
    logic [VW-1:0]           rd_data_reg;
    logic                    hit_reg;
    logic                    pend_reg;
    logic                    out_valid_reg;
    logic [INDEX_W-1:0]      index_reg;
    logic [COLOR_W-1:0]      color_reg;
    logic [USED_W-1:0]       used_reg;
    logic                    bad_out_reg;
    logic                    last_out_reg;

    logic [EW-1:0] vc_ext;
    logic [EW-1:0] n_eff;
    logic [VW-1:0] n_m1;
    logic [EW-1:0] a_ext;
    logic [EW-1:0] b_ext;
    logic          edge_bad;
    logic [VW-1:0] ia;
    logic [VW-1:0] ib;
    logic [VW-1:0] rd_addr;
    logic          rd_en;
    logic          graph_done;

    // configuration is to be written only while idle; the block does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCOUNT_RESET;
        end
        else if (cfg_valid)
        begin
            vcount_reg <= cfg_data;
        end
    end

    // clamp vertex count to 1..MAX_VERTICES
    always_comb
    begin
        vc_ext = EW'(vcount_reg);
        if (vc_ext == '0)
        begin
            n_eff = EW'(1);
        end
        else if (vc_ext > EW'(MAX_VERTICES))
        begin
            n_eff = EW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = vc_ext;
        end
    end

    assign n_m1 = VW'(n_eff - EW'(1));

    // endpoint check
    assign a_ext    = EW'(vertex_a);
    assign b_ext    = EW'(vertex_b);
    assign edge_bad = (vertex_a == '0) || (vertex_b == '0) || (a_ext > n_eff) || (b_ext > n_eff);
    assign ia       = VW'(vertex_a - VERTEX_W'(1));
    assign ib       = VW'(vertex_b - VERTEX_W'(1));

    assign graph_done = cmd.emit_load && sts.last_vertex;

    // adjacency matrix and sticky bad-edge flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                adj_reg[i] <= '0;
            end
            bad_flag_reg <= 1'b0;
        end
        else if (graph_done)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                adj_reg[i] <= '0;
            end
            bad_flag_reg <= 1'b0;
        end
        else if (cmd.load_edge)
        begin
            if (edge_bad)
            begin
                bad_flag_reg <= 1'b1;
            end
            else
            begin
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    if (ia == VW'(i))
                    begin
                        adj_reg[i][ib] <= 1'b1;
                    end
                    if (ib == VW'(i))
                    begin
                        adj_reg[i][ia] <= 1'b1;
                    end
                end
            end
        end
    end

    // color memory, one write and one registered read port
    assign rd_addr = cmd.emit_read ? u_reg : v_reg;
    assign rd_en   = cmd.emit_read || cmd.scan_step;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            color_mem[u_reg] <= c_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= color_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= adj_reg[u_reg][v_reg];
    end

    // vertex, neighbor and color counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_reg     <= '0;
            v_reg     <= '0;
            c_reg     <= '0;
            maxc_reg  <= '0;
            taken_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.scan_step;
            if (cmd.start)
            begin
                u_reg     <= '0;
                v_reg     <= '0;
                c_reg     <= '0;
                maxc_reg  <= '0;
                taken_reg <= '0;
            end
            else if (cmd.commit)
            begin
                if (c_reg > maxc_reg)
                begin
                    maxc_reg <= c_reg;
                end
                u_reg     <= sts.last_vertex ? '0 : u_reg + VW'(1);
                v_reg     <= '0;
                c_reg     <= '0;
                taken_reg <= '0;
            end
            else if (cmd.emit_load)
            begin
                u_reg <= u_reg + VW'(1);
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    v_reg <= v_reg + VW'(1);
                end
                if (pend_reg && hit_reg)
                begin
                    taken_reg[rd_data_reg] <= 1'b1;
                end
                if (cmd.search_step)
                begin
                    c_reg <= c_reg + VW'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            index_reg    <= INDEX_W'(u_reg);
            color_reg    <= COLOR_W'(rd_data_reg);
            used_reg     <= USED_W'(EW'(maxc_reg) + EW'(1));
            bad_out_reg  <= bad_flag_reg;
            last_out_reg <= sts.last_vertex;
        end
    end

    assign out_valid     = out_valid_reg;
    assign vertex_index  = index_reg;
    assign color         = color_reg;
    assign colors_used   = used_reg;
    assign bad_edge_seen = bad_out_reg;
    assign last_result   = last_out_reg;

    // status
    assign sts.start_req   = last_edge;
    assign sts.scan_end    = (v_reg == u_reg);
    assign sts.search_done = (c_reg == n_m1) || !taken_reg[c_reg];
    assign sts.last_vertex = (u_reg == n_m1);
    assign sts.out_free    = !out_valid_reg || !out_stall;

endmodule

`default_nettype wire

// ===== rtl/core/greedy_graph_coloring_unit.sv =====
// greedy_graph_coloring_unit: top level, first-fit greedy graph coloring
// depends on ggc_pkg, ggc_ctrl and ggc_datapath
// flow: an edge transaction loads while idle; the last edge starts a pass that, per vertex u,
//   scans vertices v < u and then searches its first free color, followed by one result per vertex
// throughput: 1 edge per cycle while idle; edges stall during coloring and emission
// reset: rst_n clears matrix, flag and control; vertex_count returns to 32
`default_nettype none

module greedy_graph_coloring_unit
    import ggc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration write channel, vertex count
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [VCOUNT_W-1:0] cfg_data,
    // edge input channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [VERTEX_W-1:0] vertex_a,
    input  wire logic [VERTEX_W-1:0] vertex_b,
    input  wire logic                last_edge,
    // color result channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [INDEX_W-1:0]       vertex_index,
    output logic [COLOR_W-1:0]       color,
    output logic [USED_W-1:0]        colors_used,
    output logic                     bad_edge_seen,
    output logic                     last_result
);

    // command and status between sequencer and datapath
    ggc_cmd_t cmd;
    ggc_sts_t sts;

    // the sequencer walks each vertex u over all lower vertices v < u
    // (one color memory read per cycle), then steps the first free color
    // one candidate per cycle; emission reads one stored color per result
    ggc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // adjacency rows, color memory, counters and the output register;
    // the last result may wait in the output register while new edges load
    ggc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .vertex_a      (vertex_a),
        .vertex_b      (vertex_b),
        .last_edge     (last_edge),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex_index  (vertex_index),
        .color         (color),
        .colors_used   (colors_used),
        .bad_edge_seen (bad_edge_seen),
        .last_result   (last_result)
    );

endmodule

`default_nettype wire
